// ===== hw/rtl/lpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page frame replacer package
// Sizes, field types and the frame compare result shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

	localparam int FRAMES  = 8;
	localparam int PAGE_W  = 16;
	localparam int FRAME_W = $clog2(FRAMES);
	localparam int RANK_W  = FRAME_W;
	localparam int CFG_W   = 4;
	localparam int FAULT_W = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FRAME_W-1:0] frame_idx_t;
	typedef logic [RANK_W-1:0]  rank_t;
	typedef logic [CFG_W-1:0]   cfg_t;
	typedef logic [FAULT_W-1:0] fault_t;

	typedef struct packed {
		logic match;
		logic empty;
		logic older;
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpfr_if.sv =====
// ----------------------------------------------------------------------------
// LRU page frame replacer channels
// Request channel carrying a page reference, response channel carrying the
// lookup outcome.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfr_req_if;
	logic           valid;
	logic           ready;
	lpfr_pkg::page_t page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

interface lpfr_rsp_if;
	logic                valid;
	logic                ready;
	logic                hit;
	lpfr_pkg::frame_idx_t frame_index;
	logic                evicted_valid;
	lpfr_pkg::page_t     evicted_page;
	lpfr_pkg::fault_t    fault_total;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_total, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lru_page_frame_replacer.sv =====
// ----------------------------------------------------------------------------
// LRU page frame replacer
// Page reference lookup over a small frame table with least recently used
// replacement and a saturating fault count.
// ----------------------------------------------------------------------------
// A reference is handled in a scan and a commit state: a single compare unit
// visits one frame per cycle, stopping early on a hit, otherwise walking all
// frames in use (set by cfg_q, clamped to 1..8), and the commit state then
// commits the table update and loads the response register. The request
// side is ready only while idle; a waiting response does not block the next
// request, but its commit holds until the response register is free.
`default_nettype none

module lru_page_frame_replacer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire lpfr_pkg::cfg_t    cfg_wdata,
	lpfr_req_if.sink               req,
	lpfr_rsp_if.source             rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t                 state_q;
	lpfr_pkg::cfg_t         cfg_q;
	lpfr_pkg::page_t        page_q;
	lpfr_pkg::frame_idx_t   last_q;
	lpfr_pkg::frame_idx_t   idx_q;
	logic                   hit_q;
	logic                   found_empty_q;
	lpfr_pkg::frame_idx_t   sel_q;
	lpfr_pkg::frame_idx_t   best_q;
	lpfr_pkg::rank_t        best_rank_q;
	lpfr_pkg::fault_t       fault_q;
	logic                   rsp_valid_q;

	logic                   valid_q [lpfr_pkg::FRAMES];
	lpfr_pkg::page_t        fpage_q [lpfr_pkg::FRAMES];
	lpfr_pkg::rank_t        rank_q  [lpfr_pkg::FRAMES];

	logic                   rsp_hit_q;
	lpfr_pkg::frame_idx_t   rsp_frame_q;
	logic                   rsp_ev_valid_q;
	lpfr_pkg::page_t        rsp_ev_page_q;

	lpfr_pkg::frame_idx_t   last_n;
	lpfr_pkg::cmp_res_t     cmp;
	logic                   take_best;
	logic                   commit;
	logic                   fill;
	lpfr_pkg::frame_idx_t   tgt;
	lpfr_pkg::rank_t        tgt_rank;
	lpfr_pkg::fault_t       fault_next;

	always_comb begin
		if (cfg_q == '0) begin
			last_n = '0;
		end else if (int'(cfg_q) > lpfr_pkg::FRAMES) begin
			last_n = lpfr_pkg::FRAME_W'(lpfr_pkg::FRAMES - 1);
		end else begin
			last_n = lpfr_pkg::FRAME_W'(int'(cfg_q) - 1);
		end
	end

	lpfr_cmp u_cmp (
		.frame_valid (valid_q[idx_q]),
		.frame_page  (fpage_q[idx_q]),
		.frame_rank  (rank_q[idx_q]),
		.page        (page_q),
		.best_rank   (best_rank_q),
		.res         (cmp)
	);

	assign take_best  = (idx_q == '0) || cmp.older;
	assign commit     = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp.ready);
	assign fill       = !hit_q && found_empty_q;
	assign tgt        = (hit_q || found_empty_q) ? sel_q : best_q;
	assign tgt_rank   = rank_q[tgt];
	assign fault_next = (hit_q || fault_q == '1) ? fault_q : fault_q + lpfr_pkg::FAULT_W'(1);

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.frame_index   = rsp_frame_q;
	assign rsp.evicted_valid = rsp_ev_valid_q;
	assign rsp.evicted_page  = rsp_ev_page_q;
	assign rsp.fault_total   = fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cfg_q         <= lpfr_pkg::CFG_RESET;
			idx_q         <= '0;
			last_q        <= '0;
			hit_q         <= 1'b0;
			found_empty_q <= 1'b0;
			fault_q       <= '0;
			rsp_valid_q   <= 1'b0;
			for (int i = 0; i < lpfr_pkg::FRAMES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						idx_q         <= '0;
						last_q        <= last_n;
						hit_q         <= 1'b0;
						found_empty_q <= 1'b0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cmp.match) begin
						hit_q   <= 1'b1;
						state_q <= ST_COMMIT;
					end else begin
						if (cmp.empty) begin
							found_empty_q <= 1'b1;
						end
						if (idx_q == last_q) begin
							state_q <= ST_COMMIT;
						end else begin
							idx_q <= idx_q + lpfr_pkg::FRAME_W'(1);
						end
					end
				end
				ST_COMMIT: begin
					if (commit) begin
						valid_q[tgt] <= 1'b1;
						fault_q      <= fault_next;
						rsp_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			page_q <= req.page;
		end
		if (state_q == ST_SCAN) begin
			if (cmp.match || (cmp.empty && !found_empty_q)) begin
				sel_q <= idx_q;
			end
			if (take_best) begin
				best_q      <= idx_q;
				best_rank_q <= rank_q[idx_q];
			end
		end
		if (commit) begin
			for (int i = 0; i < lpfr_pkg::FRAMES; i++) begin
				if (fill) begin
					if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + lpfr_pkg::RANK_W'(1);
					end
				end else if (valid_q[i] && lpfr_pkg::FRAME_W'(i) != tgt
					&& rank_q[i] < tgt_rank) begin
					rank_q[i] <= rank_q[i] + lpfr_pkg::RANK_W'(1);
				end
			end
			rank_q[tgt] <= '0;
			if (!hit_q) begin
				fpage_q[tgt] <= page_q;
			end
			rsp_hit_q      <= hit_q;
			rsp_frame_q    <= tgt;
			rsp_ev_valid_q <= !hit_q && !found_empty_q;
			rsp_ev_page_q  <= (!hit_q && !found_empty_q) ? fpage_q[tgt] : '0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lpfr_cmp.sv =====
// ----------------------------------------------------------------------------
// LRU page frame replacer frame compare unit
// Checks one frame against the referenced page and the oldest rank so far.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_cmp (
	input  wire logic              frame_valid,
	input  wire lpfr_pkg::page_t   frame_page,
	input  wire lpfr_pkg::rank_t   frame_rank,
	input  wire lpfr_pkg::page_t   page,
	input  wire lpfr_pkg::rank_t   best_rank,
	output lpfr_pkg::cmp_res_t     res
);

	always_comb begin
		res.match = frame_valid && (frame_page == page);
		res.empty = !frame_valid;
		res.older = frame_rank > best_rank;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lpfr_chk.sv =====
// ----------------------------------------------------------------------------
// LRU page frame replacer checker
// Port-level properties of the replacer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic              rsp_hit,
	input wire logic              rsp_evicted_valid,
	input wire lpfr_pkg::page_t   rsp_evicted_page,
	input wire lpfr_pkg::fault_t  rsp_fault_total
);

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// drop ready after taking a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> !rsp_evicted_valid)
		else $error("eviction reported on a hit");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
		else $error("evicted page not zero without eviction");

	a_fault_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_fault_total != '0)
		else $error("fault reported with zero fault count");

endmodule

bind lru_page_frame_replacer lpfr_chk u_lpfr_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_hit           (rsp.hit),
	.rsp_evicted_valid (rsp.evicted_valid),
	.rsp_evicted_page  (rsp.evicted_page),
	.rsp_fault_total   (rsp.fault_total)
);

`default_nettype wire
